### rtl/lz_rle_pattern_decompressor_macros.svh
// Assertion macros shared by the decompressor modules.
// Each macro expects clk and arst_n to be visible in the module that uses it.
`ifndef LZ_RLE_PATTERN_DECOMPRESSOR_MACROS_SVH
`define LZ_RLE_PATTERN_DECOMPRESSOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LZRP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LZRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/lzrp_pkg.sv
`default_nettype none

package lzrp_pkg;

	// Field and state widths.
	localparam int BYTE_W  = 8;
	localparam int COUNT_W = 32;
	localparam int RUN_W   = 14;
	localparam int DIST_W  = 11;
	localparam int PLEN_W  = 7;
	localparam int REPS_W  = 9;

	// Item codes on the mode field.
	typedef enum logic [1:0] {
		MODE_PUSH = 2'd0,
		MODE_TICK = 2'd1,
		MODE_END  = 2'd2,
		MODE_NOP  = 2'd3
	} mode_t;

	// Decoder phases.
	typedef enum logic [3:0] {
		PH_CMD      = 4'd0,
		PH_LIT_EXT  = 4'd1,
		PH_LIT_WAIT = 4'd2,
		PH_LIT_HOLD = 4'd3,
		PH_RUN_EXT  = 4'd4,
		PH_RUN_VAL  = 4'd5,
		PH_RUN_EMIT = 4'd6,
		PH_REF_DIST = 4'd7,
		PH_REF_EMIT = 4'd8,
		PH_PAT_REPS = 4'd9,
		PH_PAT_FILL = 4'd10,
		PH_PAT_EMIT = 4'd11
	} phase_t;

	// One result item.
	typedef struct packed {
		logic              out_valid;
		logic [BYTE_W-1:0] out_byte;
		logic              byte_taken;
		logic              need_input;
		logic              finished;
	} res_t;

endpackage

`default_nettype wire

### rtl/lzrp_ram.sv
`default_nettype none

module lzrp_ram
	import lzrp_pkg::*;
#(
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [BYTE_W-1:0]        wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [BYTE_W-1:0]        rdata
);

	logic [BYTE_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read; a write to the same address in the same cycle is passed through.
	always_ff @(posedge clk) begin
		if (we && (waddr == raddr)) begin
			rdata <= wdata;
		end else begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### rtl/lzrp_core.sv
`default_nettype none
`include "lz_rle_pattern_decompressor_macros.svh"

module lzrp_core
	import lzrp_pkg::*;
#(
	parameter int WINDOW_DEPTH  = 1024,
	parameter int PATTERN_DEPTH = 65
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               go,
	input  wire mode_t              mode,
	input  wire logic [BYTE_W-1:0]  in_byte,
	input  wire logic [COUNT_W-1:0] out_size,
	output res_t                    res
);

	localparam int WAW = $clog2(WINDOW_DEPTH);
	localparam int PAW = $clog2(PATTERN_DEPTH);
	localparam logic [PLEN_W:0] PAT_LIMIT = (PLEN_W + 1)'(PATTERN_DEPTH);

	// Decoder state.
	phase_t              phase_q, phase_d;
	logic [COUNT_W-1:0]  bp_q, bp_d;
	logic [RUN_W-1:0]    rem_q, rem_d;
	logic [DIST_W-1:0]   dist_q, dist_d;
	logic [BYTE_W-1:0]   value_q, value_d;
	logic [PLEN_W-1:0]   plen_q, plen_d;
	logic [PLEN_W-1:0]   pos_q, pos_d;
	logic [REPS_W-1:0]   reps_q, reps_d;
	logic                ended_q, ended_d;

	// Memory ports.
	logic                win_we;
	logic [WAW-1:0]      win_raddr;
	logic [BYTE_W-1:0]   win_wdata;
	logic [BYTE_W-1:0]   win_rdata;
	logic                pat_we;
	logic [BYTE_W-1:0]   pat_rdata;

	logic                done;
	logic                emitting;
	logic                emitting_d;
	logic                done_d;
	res_t                res_c;

	assign done     = bp_q >= out_size;
	assign emitting = phase_q inside {PH_LIT_HOLD, PH_RUN_EMIT, PH_REF_EMIT, PH_PAT_EMIT};

	// History window: written at the produced count, read through a registered port at the next-state address.
	lzrp_ram #(.DEPTH(WINDOW_DEPTH)) u_window (
		.clk   (clk),
		.we    (win_we),
		.waddr (bp_q[WAW-1:0]),
		.wdata (win_wdata),
		.raddr (win_raddr),
		.rdata (win_rdata)
	);

	// Pattern store: filled and read at the pattern position.
	lzrp_ram #(.DEPTH(PATTERN_DEPTH)) u_pattern (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pos_q[PAW-1:0]),
		.wdata (in_byte),
		.raddr (pos_d[PAW-1:0]),
		.rdata (pat_rdata)
	);

	// Next state and result for the item in the input register.
	always_comb begin
		logic [BYTE_W-1:0] v;
		logic [PLEN_W-1:0] pos_inc;
		v          = '0;
		pos_inc    = pos_q + PLEN_W'(1);
		phase_d    = phase_q;
		bp_d       = bp_q;
		rem_d      = rem_q;
		dist_d     = dist_q;
		value_d    = value_q;
		plen_d     = plen_q;
		pos_d      = pos_q;
		reps_d     = reps_q;
		ended_d    = ended_q;
		win_we     = 1'b0;
		pat_we     = 1'b0;
		res_c      = '0;

		if (go) begin
			unique case (mode)
				MODE_PUSH: begin
					if (!done && !ended_q && !emitting) begin
						res_c.byte_taken = 1'b1;
						unique case (phase_q)
							PH_CMD: begin
								if (in_byte[7]) begin
									if (in_byte[6]) begin
										rem_d   = RUN_W'(in_byte[4:0]) + RUN_W'(2);
										phase_d = in_byte[5] ? PH_RUN_EXT : PH_RUN_VAL;
									end else begin
										rem_d   = RUN_W'(in_byte[5:2]) + RUN_W'(2);
										dist_d  = {1'b0, in_byte[1:0], 8'h00};
										phase_d = PH_REF_DIST;
									end
								end else begin
									if (in_byte[6]) begin
										plen_d  = {1'b0, in_byte[5:0]} + PLEN_W'(2);
										pos_d   = '0;
										phase_d = PH_PAT_REPS;
									end else begin
										rem_d   = RUN_W'(in_byte[4:0]) + RUN_W'(1);
										phase_d = in_byte[5] ? PH_LIT_EXT : PH_LIT_WAIT;
									end
								end
							end
							PH_LIT_EXT: begin
								rem_d   = rem_q + {1'b0, in_byte, 5'b0};
								phase_d = PH_LIT_WAIT;
							end
							PH_LIT_WAIT: begin
								value_d = in_byte;
								phase_d = PH_LIT_HOLD;
							end
							PH_RUN_EXT: begin
								rem_d   = rem_q + {1'b0, in_byte, 5'b0};
								phase_d = PH_RUN_VAL;
							end
							PH_RUN_VAL: begin
								value_d = in_byte;
								phase_d = PH_RUN_EMIT;
							end
							PH_REF_DIST: begin
								dist_d  = dist_q + DIST_W'(in_byte) + DIST_W'(1);
								phase_d = PH_REF_EMIT;
							end
							PH_PAT_REPS: begin
								reps_d  = REPS_W'(in_byte) + REPS_W'(1);
								phase_d = PH_PAT_FILL;
							end
							PH_PAT_FILL: begin
								pat_we = {1'b0, pos_q} < PAT_LIMIT;
								pos_d  = pos_inc;
								if (pos_inc >= plen_q) begin
									pos_d   = '0;
									phase_d = PH_PAT_EMIT;
								end
							end
							default: begin
							end
						endcase
					end
				end
				MODE_TICK: begin
					if (!done && (emitting || ended_q)) begin
						unique case (phase_q)
							PH_LIT_HOLD: begin
								v       = value_q;
								rem_d   = rem_q - RUN_W'(1);
								phase_d = (rem_d != '0) ? PH_LIT_WAIT : PH_CMD;
							end
							PH_RUN_EMIT: begin
								v     = value_q;
								rem_d = rem_q - RUN_W'(1);
								if (rem_d == '0) begin
									phase_d = PH_CMD;
								end
							end
							PH_REF_EMIT: begin
								// A reference reaching before the first byte reads zero.
								if ({{(COUNT_W - DIST_W){1'b0}}, dist_q} <= bp_q) begin
									v = win_rdata;
								end
								rem_d = rem_q - RUN_W'(1);
								if (rem_d == '0) begin
									phase_d = PH_CMD;
								end
							end
							PH_PAT_EMIT: begin
								if ({1'b0, pos_q} < PAT_LIMIT) begin
									v = pat_rdata;
								end
								pos_d = pos_inc;
								if (pos_inc >= plen_q) begin
									pos_d  = '0;
									reps_d = reps_q - REPS_W'(1);
									if (reps_d == '0) begin
										phase_d = PH_CMD;
									end
								end
							end
							default: begin
								// Padding after the end of input.
								v = '0;
							end
						endcase
						win_we          = 1'b1;
						bp_d            = bp_q + COUNT_W'(1);
						res_c.out_valid = 1'b1;
						res_c.out_byte  = v;
					end
				end
				MODE_END: begin
					ended_d = 1'b1;
				end
				default: begin
				end
			endcase
		end

		win_wdata = v;
	end

	// Status after the item, and the window address for the next one.
	assign emitting_d = phase_d inside {PH_LIT_HOLD, PH_RUN_EMIT, PH_REF_EMIT, PH_PAT_EMIT};
	assign done_d     = bp_d >= out_size;
	assign win_raddr  = bp_d[WAW-1:0] - dist_d[WAW-1:0];

	// The status flags are reported on every result.
	logic res_need_input;
	logic res_finished;
	assign res_need_input = !done_d && !ended_d && !emitting_d;
	assign res_finished   = done_d;
	assign res = {res_c.out_valid, res_c.out_byte, res_c.byte_taken, res_need_input,
		res_finished};

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_CMD;
			bp_q    <= '0;
			rem_q   <= '0;
			dist_q  <= '0;
			value_q <= '0;
			plen_q  <= '0;
			pos_q   <= '0;
			reps_q  <= '0;
			ended_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			bp_q    <= bp_d;
			rem_q   <= rem_d;
			dist_q  <= dist_d;
			value_q <= value_d;
			plen_q  <= plen_d;
			pos_q   <= pos_d;
			reps_q  <= reps_d;
			ended_q <= ended_d;
		end
	end

	// Assertions.
	`LZRP_ASSERT_NEXT(a_count_step, go && res.out_valid, bp_q == $past(bp_q) + COUNT_W'(1), "produced count did not step with an output byte")
	`LZRP_ASSERT_NEXT(a_hold_idle, !go, $stable(phase_q) && $stable(bp_q), "decoder state moved without an item")
	`LZRP_ASSERT_NOW(a_ref_live, phase_q == PH_REF_EMIT, dist_q != '0 && rem_q != '0, "back-reference active with zero distance or length")
	`LZRP_ASSERT_NOW(a_pat_live, phase_q == PH_PAT_EMIT, reps_q != '0 && pos_q < plen_q, "pattern emit outside its bounds")

endmodule

`default_nettype wire

### rtl/lz_rle_pattern_decompressor.sv
// LZ decompressor with literal runs, byte runs, back-references and repeated
// patterns. Each input item (push, tick, end or no-op) yields exactly one result
// item in the result register, and the block sustains one item per clock while
// res_stall does not hold the result register: the decoder state, its next-state
// logic and the two on-chip memories (a 1024-byte history window and a 65-byte
// pattern store) close their loop within each item, with the memory reads issued
// ahead from the next-state address. No clearing pass runs after reset. Write
// out_size through cfg_wen/cfg_wdata while the block is idle.
`default_nettype none
`include "lz_rle_pattern_decompressor_macros.svh"

module lz_rle_pattern_decompressor
	import lzrp_pkg::*;
#(
	parameter int WINDOW_DEPTH  = 1024,
	parameter int PATTERN_DEPTH = 65
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Configuration port.
	input  wire logic               cfg_wen,
	input  wire logic [COUNT_W-1:0] cfg_wdata,
	// Input channel.
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [1:0]         mode,
	input  wire logic [BYTE_W-1:0]  in_byte,
	// Result channel.
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic                    out_valid,
	output logic      [BYTE_W-1:0]  out_byte,
	output logic                    byte_taken,
	output logic                    need_input,
	output logic                    finished
);

	logic [COUNT_W-1:0] out_size_q;
	logic               item_valid_s1;
	mode_t              mode_s1;
	logic [BYTE_W-1:0]  in_byte_s1;
	logic               advance;
	logic               res_valid_q;
	res_t               res_q;
	res_t               core_res;

	// The item advances when the result register is empty or being drained.
	assign advance    = item_valid_s1 && (!res_valid_q || !res_stall);
	assign item_stall = item_valid_s1 && !advance;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_size_q <= '0;
		end else if (cfg_wen) begin
			out_size_q <= cfg_wdata;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			item_valid_s1 <= 1'b1;
		end else if (advance) begin
			item_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			mode_s1    <= mode_t'(mode);
			in_byte_s1 <= in_byte;
		end
	end

	// Decoder.
	lzrp_core #(
		.WINDOW_DEPTH  (WINDOW_DEPTH),
		.PATTERN_DEPTH (PATTERN_DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (advance),
		.mode     (mode_s1),
		.in_byte  (in_byte_s1),
		.out_size (out_size_q),
		.res      (core_res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= core_res;
		end
	end

	assign res_valid  = res_valid_q;
	assign out_valid  = res_q.out_valid;
	assign out_byte   = res_q.out_byte;
	assign byte_taken = res_q.byte_taken;
	assign need_input = res_q.need_input;
	assign finished   = res_q.finished;

	// Assertions.
	`LZRP_ASSERT_NOW(a_taken_push, advance && core_res.byte_taken, mode_s1 == MODE_PUSH, "byte taken on an item that is not a push")
	`LZRP_ASSERT_NOW(a_out_tick, advance && core_res.out_valid, mode_s1 == MODE_TICK, "output byte on an item that is not a tick")
	`LZRP_ASSERT_NEXT(a_res_load, advance, res_valid_q && res_q == $past(core_res), "result register missed a transfer")

endmodule

`default_nettype wire
